[rtl/ccfl_pkg.sv]
// Shared types, constants and helpers for the per-cell CFL number unit.
// Depends on nothing; every other file imports it.
package ccfl_pkg;

    localparam int DIMENSIONS    = 3;
    localparam int FRACTION_BITS = 16;
    localparam int QUOT_BITS     = 34;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int IN_DATA_W     = 280;
    localparam int OUT_DATA_W    = 96;

    localparam logic [30:0] KMAX   = 31'h7FFF_FFFF;
    localparam logic [31:0] ONE_Q  = 32'd1 << FRACTION_BITS;

    localparam logic [1:0] KIND_CENTER   = 2'd0;
    localparam logic [1:0] KIND_FACE     = 2'd1;
    localparam logic [1:0] KIND_SOLUTION = 2'd2;
    localparam logic [1:0] KIND_UNKNOWN  = 2'd3;

    localparam logic CFG_TIME_STEP  = 1'b0;
    localparam logic CFG_TINY_VALUE = 1'b1;

    typedef struct packed {
        logic [1:0]       kind;
        logic [2:0][31:0] coord;
        logic [30:0]      density;
        logic [2:0][31:0] mom_abs;
        logic [31:0]      total_energy;
        logic [18:0]      heat_ratio;
        logic [19:0]      heat_less_one;   // gamma - 1, two's complement
    } ccfl_item_t;

    typedef struct packed {
        logic        start;
        logic        is_sqrt;
        logic [63:0] num;
        logic [31:0] den;
    } ccfl_iter_req_t;

    typedef struct packed {
        logic                 done;
        logic [QUOT_BITS-1:0] quot;
        logic                 ovf;
        logic                 dz;
        logic                 num_nz;
    } ccfl_iter_rsp_t;

    // Saturating unsigned quotient: {saturated, value}
    function automatic logic [31:0] sat_u31(input ccfl_iter_rsp_t r);
        logic [31:0] res;
        if (r.dz)
            res = {1'b1, (r.num_nz ? KMAX : 31'd0)};
        else if (r.ovf || (r.quot[QUOT_BITS-1:31] != '0))
            res = {1'b1, KMAX};
        else
            res = {1'b0, r.quot[30:0]};
        return res;
    endfunction

endpackage

[rtl/ccfl_front.sv]
// Front end: accepts stream transactions, drops unknown kinds and
// precomputes magnitudes. Depends on ccfl_pkg.
module ccfl_front
    import ccfl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // coord_x, coord_y, coord_z, density, momentum_x/y/z, total_energy, heat_ratio
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    // kind
    input  logic [1:0]           s_axis_tuser,
    output logic                 push,
    output ccfl_item_t           push_item,
    input  logic                 q_full
);

    logic       stage_vld_reg;
    ccfl_item_t stage_reg;
    ccfl_item_t item_in;
    logic       accept;
    logic [2:0][31:0] mom;

    assign mom[0] = s_axis_tdata[158:127];
    assign mom[1] = s_axis_tdata[190:159];
    assign mom[2] = s_axis_tdata[222:191];

    always_comb
    begin
        item_in.kind          = s_axis_tuser;
        item_in.coord[0]      = s_axis_tdata[31:0];
        item_in.coord[1]      = s_axis_tdata[63:32];
        item_in.coord[2]      = s_axis_tdata[95:64];
        item_in.density       = s_axis_tdata[126:96];
        for (int i = 0; i < 3; i++)
        begin
            item_in.mom_abs[i] = mom[i][31] ? (~mom[i] + 32'd1) : mom[i];
        end
        item_in.total_energy  = s_axis_tdata[254:223];
        item_in.heat_ratio    = s_axis_tdata[273:255];
        item_in.heat_less_one = {1'b0, s_axis_tdata[273:255]} - ONE_Q[19:0];
    end

    assign push          = stage_vld_reg && !q_full;
    assign s_axis_tready = !stage_vld_reg || !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push_item     = stage_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_vld_reg <= 1'b0;
        end
        else
        begin
            if (accept && (s_axis_tuser != KIND_UNKNOWN))
                stage_vld_reg <= 1'b1;
            else if (push)
                stage_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (s_axis_tuser != KIND_UNKNOWN))
            stage_reg <= item_in;
    end

endmodule

[rtl/ccfl_queue.sv]
// Short queue between front end and sequencer.
// Depends on ccfl_pkg.
module ccfl_queue
    import ccfl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  ccfl_item_t push_item,
    output logic       full,
    input  logic       pop,
    output ccfl_item_t head,
    output logic       empty
);

    ccfl_item_t        mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

endmodule

[rtl/ccfl_iter.sv]
// Shared iterative unit: restoring divide (one quotient bit a cycle) and
// digit-by-digit square root (one root bit a cycle). Depends on ccfl_pkg.
module ccfl_iter
    import ccfl_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  ccfl_iter_req_t req,
    output ccfl_iter_rsp_t rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [5:0]           cnt_reg;
    logic                 sqrt_reg;
    logic [63:0]          work_reg;
    logic [31:0]          den_reg;
    logic [33:0]          rem_reg;
    logic [QUOT_BITS-1:0] quot_reg;
    logic                 ovf_reg;
    logic                 dz_reg;
    logic                 nz_reg;

    logic [32:0] div_r;
    logic        div_ge;
    logic [32:0] div_rem;
    logic [35:0] sq_r;
    logic [35:0] sq_trial;
    logic        sq_ge;
    logic [35:0] sq_rem;

    assign div_r    = {rem_reg[31:0], work_reg[QUOT_BITS-1]};
    assign div_ge   = div_r >= {1'b0, den_reg};
    assign div_rem  = div_ge ? (div_r - {1'b0, den_reg}) : div_r;
    assign sq_r     = {rem_reg, work_reg[63:62]};
    assign sq_trial = {quot_reg, 2'b01};
    assign sq_ge    = sq_r >= sq_trial;
    assign sq_rem   = sq_ge ? (sq_r - sq_trial) : sq_r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.is_sqrt ? 6'd31 : 6'(QUOT_BITS - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 6'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            sqrt_reg <= req.is_sqrt;
            work_reg <= req.num;
            den_reg  <= req.den;
            quot_reg <= '0;
            rem_reg  <= req.is_sqrt ? 34'd0 : {4'd0, req.num[63:QUOT_BITS]};
            ovf_reg  <= {2'b00, req.num} >= {req.den, {QUOT_BITS{1'b0}}};
            dz_reg   <= (req.den == '0);
            nz_reg   <= (req.num != '0);
        end
        else if (busy_reg)
        begin
            if (sqrt_reg)
            begin
                rem_reg  <= sq_rem[33:0];
                quot_reg <= {quot_reg[QUOT_BITS-2:0], sq_ge};
                work_reg <= {work_reg[61:0], 2'b00};
            end
            else
            begin
                rem_reg  <= {1'b0, div_rem};
                quot_reg <= {quot_reg[QUOT_BITS-2:0], div_ge};
                work_reg <= {work_reg[62:0], 1'b0};
            end
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.quot   = quot_reg;
    assign rsp.ovf    = ovf_reg;
    assign rsp.dz     = dz_reg;
    assign rsp.num_nz = nz_reg;

endmodule

[rtl/ccfl_back.sv]
// Back end sequencer: face distances, pressure, wave speed, CFL and
// corrected energy over a shared multiplier and ccfl_iter. Depends on ccfl_pkg.
module ccfl_back
    import ccfl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [0:0]            cfg_index,
    input  logic [30:0]           cfg_data,
    input  ccfl_item_t            head,
    input  logic                  empty,
    output logic                  pop,
    output ccfl_iter_req_t        req,
    input  ccfl_iter_rsp_t        rsp,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // cfl, raw_cfl, corrected_energy, saturated
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam logic [4:0] ST_IDLE = 5'd0,  ST_SQ   = 5'd1,  ST_ACC  = 5'd2,
                           ST_WAIT = 5'd3,  ST_FMIN = 5'd4,  ST_KED  = 5'd5,
                           ST_PMUL = 5'd6,  ST_PR   = 5'd7,  ST_QMUL = 5'd8,
                           ST_QST  = 5'd9,  ST_QD   = 5'd10, ST_CD   = 5'd11,
                           ST_SD   = 5'd12, ST_UD   = 5'd13, ST_RMUL = 5'd14,
                           ST_RST  = 5'd15, ST_RD   = 5'd16, ST_TMUL = 5'd17,
                           ST_TST  = 5'd18, ST_TD   = 5'd19, ST_GD   = 5'd20,
                           ST_OUT  = 5'd21;

    localparam int PAD_Q = 64 - 31 - FRACTION_BITS;
    localparam int PAD_S = 64 - 32 - FRACTION_BITS;

    logic [4:0]       state_reg, state_next;
    logic [4:0]       ret_reg, ret_next;
    logic [1:0]       idx_reg, idx_next;
    logic             far_reg, far_next;
    logic             sat_reg, sat_next;
    logic             neg_reg, neg_next;
    ccfl_item_t       item_reg, item_next;
    logic [63:0]      acc_reg, acc_next;
    logic [65:0]      prod_reg, prod_next;
    logic [30:0]      ke_reg, ke_next;
    logic [30:0]      pr_reg, pr_next;
    logic [30:0]      q_reg, q_next;
    logic [30:0]      c_reg, c_next;
    logic [30:0]      ws_reg, ws_next;
    logic [30:0]      raw_reg, raw_next;
    logic [30:0]      cfl_reg, cfl_next;
    logic [31:0]      ce_reg, ce_next;
    logic [2:0][31:0] center_reg, center_next;
    logic [30:0]      min_reg, min_next;
    logic [30:0]      time_step_reg;
    logic [15:0]      tiny_reg;
    logic             out_vld_reg, out_vld_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic [32:0] mul_a, mul_b;
    logic [65:0] mul_p;
    logic [32:0] face_diff, face_abs;
    logic        face_far;
    logic [32:0] e_diff, e_abs;
    logic [19:0] ga1, ga1_abs;
    logic [31:0] tv, tv_abs;
    logic [31:0] dsat;
    logic [30:0] fd;
    logic [31:0] ws_sum;
    logic [32:0] term, pval;
    logic [36:0] prg, ce_wide;

    assign mul_p     = mul_a * mul_b;
    assign dsat      = sat_u31(rsp);
    assign face_diff = {center_reg[idx_reg][31], center_reg[idx_reg]}
                     - {item_reg.coord[idx_reg][31], item_reg.coord[idx_reg]};
    assign face_abs  = face_diff[32] ? (~face_diff + 33'd1) : face_diff;
    assign face_far  = face_abs > {2'b00, KMAX};
    assign e_diff    = {item_reg.total_energy[31], item_reg.total_energy} - {2'b00, ke_reg};
    assign e_abs     = e_diff[32] ? (~e_diff + 33'd1) : e_diff;
    assign ga1       = item_reg.heat_less_one;
    assign ga1_abs   = ga1[19] ? (~ga1 + 20'd1) : ga1;
    assign tv        = {1'b0, raw_reg} - ONE_Q;
    assign tv_abs    = tv[31] ? (~tv + 32'd1) : tv;
    assign fd        = far_reg ? KMAX
                     : ((rsp.quot[QUOT_BITS-1:31] != '0) ? KMAX : rsp.quot[30:0]);

    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        idx_next      = idx_reg;
        far_next      = far_reg;
        sat_next      = sat_reg;
        neg_next      = neg_reg;
        item_next     = item_reg;
        acc_next      = acc_reg;
        prod_next     = prod_reg;
        ke_next       = ke_reg;
        pr_next       = pr_reg;
        q_next        = q_reg;
        c_next        = c_reg;
        ws_next       = ws_reg;
        raw_next      = raw_reg;
        cfl_next      = cfl_reg;
        ce_next       = ce_reg;
        center_next   = center_reg;
        min_next      = min_reg;
        out_data_next = out_data_reg;
        out_vld_next  = out_vld_reg && !m_axis_tready;
        pop           = 1'b0;
        req           = '0;
        mul_a         = '0;
        mul_b         = '0;
        ws_sum        = {1'b0, c_reg} + {1'b0, rsp.quot[30:0]};
        term          = '0;
        pval          = '0;
        prg           = '0;
        ce_wide       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop = 1'b1;
                    if (head.kind == KIND_CENTER)
                    begin
                        center_next = head.coord;
                        min_next    = KMAX;
                    end
                    else
                    begin
                        item_next  = head;
                        idx_next   = '0;
                        acc_next   = '0;
                        far_next   = 1'b0;
                        sat_next   = 1'b0;
                        state_next = ST_SQ;
                    end
                end
            end
            ST_SQ:
            begin
                if (item_reg.kind == KIND_FACE)
                begin
                    mul_a = face_far ? 33'd0 : face_abs;
                    mul_b = face_abs;
                    if (face_far)
                        far_next = 1'b1;
                end
                else
                begin
                    mul_a = {1'b0, item_reg.mom_abs[idx_reg]};
                    mul_b = {1'b0, item_reg.mom_abs[idx_reg]};
                end
                prod_next  = mul_p;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                acc_next = acc_reg + prod_reg[63:0];
                if (idx_reg == 2'(DIMENSIONS - 1))
                begin
                    req.start  = 1'b1;
                    req.num    = acc_next;
                    state_next = ST_WAIT;
                    if (item_reg.kind == KIND_FACE)
                    begin
                        req.is_sqrt = 1'b1;
                        ret_next    = ST_FMIN;
                    end
                    else
                    begin
                        req.den  = {item_reg.density, 1'b0};
                        ret_next = ST_KED;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_SQ;
                end
            end
            ST_WAIT:
            begin
                if (rsp.done)
                    state_next = ret_reg;
            end
            ST_FMIN:
            begin
                if (fd < min_reg)
                    min_next = fd;
                state_next = ST_IDLE;
            end
            ST_KED:
            begin
                ke_next    = dsat[30:0];
                sat_next   = sat_reg | dsat[31];
                state_next = ST_PMUL;
            end
            ST_PMUL:
            begin
                mul_a      = {13'd0, ga1_abs};
                mul_b      = e_abs;
                prod_next  = mul_p;
                neg_next   = ga1[19] ^ e_diff[32];
                state_next = ST_PR;
            end
            ST_PR:
            begin
                if (!neg_reg && (prod_reg != '0))
                begin
                    if (prod_reg[65:FRACTION_BITS+31] != '0)
                    begin
                        pr_next  = KMAX;
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        pr_next = prod_reg[FRACTION_BITS+30:FRACTION_BITS];
                    end
                end
                else
                begin
                    pr_next = '0;
                end
                state_next = ST_QMUL;
            end
            ST_QMUL:
            begin
                mul_a      = {14'd0, item_reg.heat_ratio};
                mul_b      = {2'b00, pr_reg};
                prod_next  = mul_p;
                state_next = ST_QST;
            end
            ST_QST:
            begin
                req.start  = 1'b1;
                req.num    = prod_reg[63:0];
                req.den    = {1'b0, item_reg.density};
                ret_next   = ST_QD;
                state_next = ST_WAIT;
            end
            ST_QD:
            begin
                q_next      = dsat[30:0];
                sat_next    = sat_reg | dsat[31];
                req.start   = 1'b1;
                req.is_sqrt = 1'b1;
                req.num     = {{PAD_Q{1'b0}}, dsat[30:0], {FRACTION_BITS{1'b0}}};
                ret_next    = ST_CD;
                state_next  = ST_WAIT;
            end
            ST_CD:
            begin
                // zero density: sound speed follows the saturated quotient
                c_next      = (item_reg.density == '0) ? q_reg : rsp.quot[30:0];
                req.start   = 1'b1;
                req.is_sqrt = 1'b1;
                req.num     = acc_reg;
                ret_next    = ST_SD;
                state_next  = ST_WAIT;
            end
            ST_SD:
            begin
                req.start  = 1'b1;
                req.num    = {{PAD_S{1'b0}}, rsp.quot[31:0], {FRACTION_BITS{1'b0}}};
                req.den    = {1'b0, item_reg.density};
                ret_next   = ST_UD;
                state_next = ST_WAIT;
            end
            ST_UD:
            begin
                ws_sum   = {1'b0, c_reg} + {1'b0, dsat[30:0]};
                sat_next = sat_reg | dsat[31] | ws_sum[31];
                ws_next  = ws_sum[31] ? KMAX : ws_sum[30:0];
                state_next = ST_RMUL;
            end
            ST_RMUL:
            begin
                mul_a      = {3'd0, time_step_reg[30:1]};
                mul_b      = {2'b00, ws_reg};
                prod_next  = mul_p;
                state_next = ST_RST;
            end
            ST_RST:
            begin
                req.start  = 1'b1;
                req.num    = prod_reg[63:0];
                req.den    = {1'b0, min_reg};
                ret_next   = ST_RD;
                state_next = ST_WAIT;
            end
            ST_RD:
            begin
                raw_next   = dsat[30:0];
                sat_next   = sat_reg | dsat[31];
                state_next = ST_TMUL;
            end
            ST_TMUL:
            begin
                mul_a      = {1'b0, tv_abs};
                mul_b      = {2'b00, pr_reg};
                prod_next  = mul_p;
                neg_next   = tv[31];
                state_next = ST_TST;
            end
            ST_TST:
            begin
                req.start  = 1'b1;
                req.num    = prod_reg[63:0];
                req.den    = {1'b0, pr_reg} + {16'd0, tiny_reg};
                ret_next   = ST_TD;
                state_next = ST_WAIT;
            end
            ST_TD:
            begin
                // zero divisor leaves the correction term at zero
                term = rsp.dz ? 33'd0 : {2'b00, rsp.quot[30:0]};
                if (neg_reg)
                    term = ~term + 33'd1;
                pval = term + {1'b0, ONE_Q};
                if (pval[32])
                    cfl_next = '0;
                else if (pval[31])
                begin
                    cfl_next = KMAX;
                    sat_next = 1'b1;
                end
                else
                    cfl_next = pval[30:0];
                neg_next   = ga1[19];
                req.start  = 1'b1;
                req.num    = {{PAD_Q{1'b0}}, pr_reg, {FRACTION_BITS{1'b0}}};
                req.den    = {12'd0, ga1_abs};
                ret_next   = ST_GD;
                state_next = ST_WAIT;
            end
            ST_GD:
            begin
                if (rsp.ovf && !rsp.dz)
                begin
                    sat_next = 1'b1;
                    ce_next  = neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end
                else
                begin
                    if (rsp.dz)
                    begin
                        sat_next = 1'b1;
                        prg = rsp.num_nz ? {6'd0, KMAX} : 37'd0;
                    end
                    else
                    begin
                        prg = {3'd0, rsp.quot};
                        if (neg_reg)
                            prg = ~prg + 37'd1;
                    end
                    ce_wide = prg + {6'd0, ke_reg} + {21'd0, tiny_reg};
                    if ((ce_wide[36:31] == 6'h00) || (ce_wide[36:31] == 6'h3F))
                        ce_next = ce_wide[31:0];
                    else
                    begin
                        sat_next = 1'b1;
                        ce_next  = ce_wide[36] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    end
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_vld_reg || m_axis_tready)
                begin
                    out_vld_next  = 1'b1;
                    out_data_next = {1'b0, sat_reg, ce_reg, raw_reg, cfl_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_vld_reg   <= 1'b0;
            center_reg    <= '0;
            min_reg       <= KMAX;
            time_step_reg <= '0;
            tiny_reg      <= 16'd1;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
            center_reg  <= center_next;
            min_reg     <= min_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TIME_STEP:  time_step_reg <= cfg_data;
                    CFG_TINY_VALUE: tiny_reg      <= cfg_data[15:0];
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ret_reg      <= ret_next;
        idx_reg      <= idx_next;
        far_reg      <= far_next;
        sat_reg      <= sat_next;
        neg_reg      <= neg_next;
        item_reg     <= item_next;
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        ke_reg       <= ke_next;
        pr_reg       <= pr_next;
        q_reg        <= q_next;
        c_reg        <= c_next;
        ws_reg       <= ws_next;
        raw_reg      <= raw_next;
        cfl_reg      <= cfl_next;
        ce_reg       <= ce_next;
        out_data_reg <= out_data_next;
    end

endmodule

[rtl/cell_cfl_number_unit.sv]
// Per-cell CFL number unit, Q16.16. Center item: taken in the sequencer's idle state.
// Face item: one 32-step square root. Solution item: eight 32..34-step
// divide/root passes on the shared iterative unit. Front stage and 2-entry
// queue buffer input.
// Reset: cell center 0, min distance max, time_step 0, tiny_value 1.
module cell_cfl_number_unit
    import ccfl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // coord_x, coord_y, coord_z, density, momentum_x/y/z, total_energy, heat_ratio
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // kind
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // cfl, raw_cfl, corrected_energy, saturated
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  cfg_we,
    input  logic [0:0]            cfg_index,
    input  logic [30:0]           cfg_data
);

    logic           push;
    ccfl_item_t     push_item;
    logic           q_full;
    logic           q_empty;
    logic           q_pop;
    ccfl_item_t     q_head;
    ccfl_iter_req_t iter_req;
    ccfl_iter_rsp_t iter_rsp;

    ccfl_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push          (push),
        .push_item     (push_item),
        .q_full        (q_full)
    );

    ccfl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    ccfl_iter u_iter (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (iter_req),
        .rsp   (iter_rsp)
    );

    ccfl_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .head          (q_head),
        .empty         (q_empty),
        .pop           (q_pop),
        .req           (iter_req),
        .rsp           (iter_rsp),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
